// ===== rtl/core/escaped_frame_receiver_crc16_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame receiver
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_CRC16_TOP_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_CRC16_TOP_MACROS_SVH

// Property holds at every clock edge outside reset.
`define EFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define EFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// efr_pkg
// Constants, status codes and the CRC-16 byte update of the frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam logic [7:0]  START_MARK = 8'hfd;
  localparam logic [7:0]  ESC_MARK   = 8'hfc;
  localparam logic [7:0]  ESC_BIT    = 8'h80;
  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [15:0] CRC_INIT   = 16'hd77f;
  localparam logic [15:0] CRC_ZERO   = 16'h0000;

  // Width of the payload_length field
  localparam int unsigned PLEN_W = 11;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CRC   = 2'd1,
    ST_SHORT = 2'd2,
    ST_LONG  = 2'd3
  } status_e;

  // CRC-16, MSB first, one byte: eight fixed shift/xor steps
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // CRC after the start mark, seen from the initial value
  localparam logic [15:0] CRC_START = crc16_byte(CRC_INIT, START_MARK);

endpackage

// ===== rtl/core/escaped_frame_receiver_crc16_top.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc16_top
// Byte-stuffed serial frame decoder with CRC-16 check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, rx_byte_i) carries raw received
//   bytes. Bytes are dropped until a 0xfd start mark; inside a frame 0xfc
//   escapes the next byte (ORed with 0x80). Frame: start, 16-bit length,
//   destination, sequence, length-2 payload bytes, two CRC bytes.
//   Output channel (out_valid_o/out_ready_i) gives one transfer per payload
//   byte (frame_end_o = 0) and one end transfer per frame (frame_end_o = 1)
//   with status_o and payload_length_o. Bad lengths end the frame at once.
//   Discard the payload of a frame whose end status is not ok.
// Timing:
//   One byte per cycle sustained unless the output stalls. A byte lands in the
//   input register on its transfer, and its result is registered in the output
//   register, which drives out_valid_o. The CRC update is eight unrolled xor steps.
// Reset and stall:
//   Reset returns the decoder to hunting with the CRC at its initial value
//   and empties both registers. While a result waits with out_ready_i low the
//   output holds, decoding stops and in_ready_o drops once the input register
//   is full.
// ----------------------------------------------------------------------------
`include "escaped_frame_receiver_crc16_top_macros.svh"

module escaped_frame_receiver_crc16_top
  import efr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        data_byte_o,
  output logic [7:0]        destination_o,
  output logic [7:0]        sequence_res_o,
  output logic              frame_end_o,
  output logic [1:0]        status_o,
  output logic [PLEN_W-1:0] payload_length_o
);

  // Stored length never exceeds MAX_PAYLOAD+2; position never exceeds length+4
  localparam int unsigned LW = $clog2(MAX_PAYLOAD + 3);
  localparam int unsigned PW = $clog2(MAX_PAYLOAD + 7);
  localparam logic [15:0] LEN_MAX = 16'(MAX_PAYLOAD + 2);

  // Input register
  logic       s1_vld_q;
  logic [7:0] s1_byte_q;

  // Decoder state
  logic [PW-1:0] pos_q, pos_d;
  logic          esc_q, esc_d;
  logic [7:0]    hi_q, hi_d;
  logic [LW-1:0] len_q, len_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    dest_q, dest_d;
  logic [7:0]    seq_q, seq_d;

  // Output register
  logic              out_vld_q;
  logic [7:0]        out_data_q;
  logic [7:0]        out_dst_q;
  logic [7:0]        out_seq_q;
  logic              out_end_q;
  status_e           out_st_q;
  logic [PLEN_W-1:0] out_plen_q;

  // Result of the current byte
  logic              res_vld;
  logic [7:0]        res_data;
  logic [7:0]        res_dst;
  logic [7:0]        res_seq;
  logic              res_end;
  status_e           res_st;
  logic [PLEN_W-1:0] res_plen;

  logic          adv;
  logic          fire;
  logic [7:0]    ub;
  logic [15:0]   crc_new;
  logic [15:0]   len16;
  logic [PW-1:0] len_ext;

  logic          out_pay;
  logic          out_bad_len;

  assign adv        = !out_vld_q || out_ready_i;
  assign fire       = s1_vld_q && adv;
  assign in_ready_o = !s1_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  assign ub      = esc_q ? (s1_byte_q | ESC_BIT) : s1_byte_q;
  assign crc_new = crc16_byte(crc_q, ub);
  assign len16   = {hi_q, ub};
  assign len_ext = PW'(len_q);

  always_comb begin
    pos_d    = pos_q;
    esc_d    = esc_q;
    hi_d     = hi_q;
    len_d    = len_q;
    crc_d    = crc_q;
    dest_d   = dest_q;
    seq_d    = seq_q;
    res_vld  = 1'b0;
    res_data = 8'h00;
    res_dst  = 8'h00;
    res_seq  = 8'h00;
    res_end  = 1'b0;
    res_st   = ST_OK;
    res_plen = '0;

    if (pos_q == '0) begin
      // hunt: drop everything but the start mark
      if (s1_byte_q == START_MARK) begin
        crc_d = CRC_START;
        esc_d = 1'b0;
        len_d = '0;
        pos_d = PW'(1);
      end
    end else if (!esc_q && s1_byte_q == ESC_MARK) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      crc_d = crc_new;
      pos_d = pos_q + PW'(1);
      if (pos_q == PW'(1)) begin
        hi_d = ub;
      end else if (pos_q == PW'(2)) begin
        if (len16 < 16'd2 || len16 > LEN_MAX) begin
          pos_d   = '0;
          len_d   = '0;
          crc_d   = CRC_INIT;
          res_vld = 1'b1;
          res_end = 1'b1;
          res_st  = (len16 < 16'd2) ? ST_SHORT : ST_LONG;
        end else begin
          len_d = len16[LW-1:0];
        end
      end else if (pos_q == PW'(3)) begin
        dest_d = ub;
      end else if (pos_q == PW'(4)) begin
        seq_d = ub;
      end else if (pos_q < len_ext + PW'(3)) begin
        res_vld  = 1'b1;
        res_data = ub;
        res_dst  = dest_q;
        res_seq  = seq_q;
      end else if (pos_q != len_ext + PW'(3)) begin
        // last CRC byte: check residue and close the frame
        pos_d    = '0;
        len_d    = '0;
        crc_d    = CRC_INIT;
        res_vld  = 1'b1;
        res_end  = 1'b1;
        res_dst  = dest_q;
        res_seq  = seq_q;
        res_st   = (crc_new == CRC_ZERO) ? ST_OK : ST_CRC;
        res_plen = PLEN_W'(len_q - LW'(2));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      esc_q  <= 1'b0;
      hi_q   <= 8'h00;
      len_q  <= '0;
      crc_q  <= CRC_INIT;
      dest_q <= 8'h00;
      seq_q  <= 8'h00;
    end else if (fire) begin
      pos_q  <= pos_d;
      esc_q  <= esc_d;
      hi_q   <= hi_d;
      len_q  <= len_d;
      crc_q  <= crc_d;
      dest_q <= dest_d;
      seq_q  <= seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fire && res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_vld) begin
      out_data_q <= res_data;
      out_dst_q  <= res_dst;
      out_seq_q  <= res_seq;
      out_end_q  <= res_end;
      out_st_q   <= res_st;
      out_plen_q <= res_plen;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign data_byte_o      = out_data_q;
  assign destination_o    = out_dst_q;
  assign sequence_res_o   = out_seq_q;
  assign frame_end_o      = out_end_q;
  assign status_o         = out_st_q;
  assign payload_length_o = out_plen_q;

  assign out_pay     = out_vld_q && !out_end_q;
  assign out_bad_len = out_vld_q && out_end_q && (out_st_q == ST_SHORT || out_st_q == ST_LONG);

  `EFR_ASSERT_IMPL(a_esc_in_frame, esc_q, pos_q != '0, "escape pending while hunting")
  `EFR_ASSERT_IMPL(a_pos_bound, pos_q > PW'(4), pos_q <= len_ext + PW'(4), "past frame end")
  `EFR_ASSERT_IMPL(a_pay_fields, out_pay, out_st_q == ST_OK && out_plen_q == '0, "end fields set")
  `EFR_ASSERT_IMPL(a_bad_len, out_bad_len, out_plen_q == '0 && out_dst_q == '0, "nonzero fields")
  `EFR_ASSERT(a_hunt_crc, (pos_q != '0) || (crc_q == CRC_INIT), "CRC moved while hunting")

endmodule

// ===== tb/efr_frame_checker.sv =====
// ----------------------------------------------------------------------------
// efr_frame_checker
// Watches both channels of the frame receiver. It decodes every accepted raw
// byte on its own, queues the results the decoder should give, and compares
// each output transfer field by field with the oldest queued result.
// ----------------------------------------------------------------------------
package efr_tb_pkg;
  import efr_pkg::*;

  // Bit-serial form of the CRC-16 byte update, MSB first
  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : CRC_ZERO);
    end
    return c;
  endfunction

endpackage

module efr_frame_checker
  import efr_pkg::*;
  import efr_tb_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        destination_i,
  input  logic [7:0]        sequence_res_i,
  input  logic              frame_end_i,
  input  logic [1:0]        status_i,
  input  logic [PLEN_W-1:0] payload_length_i,
  output int unsigned       fail_count_o,
  output int unsigned       outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]        data;
    logic [7:0]        dest;
    logic [7:0]        seq;
    logic              is_end;
    status_e           status;
    logic [PLEN_W-1:0] plen;
  } frame_result_t;

  logic [10:0]   rx_pos;
  logic          esc_seen;
  logic [15:0]   frame_len;
  logic [15:0]   crc_acc;
  logic [7:0]    dest_q;
  logic [7:0]    seq_q;
  frame_result_t decoded_q[$];

  task automatic restart_hunt();
    rx_pos    = '0;
    esc_seen  = 1'b0;
    frame_len = '0;
    crc_acc   = CRC_INIT;
  endtask

  task automatic push_result(input logic [7:0] data, input logic [7:0] dest,
                             input logic [7:0] seq, input logic is_end,
                             input status_e st, input logic [PLEN_W-1:0] plen);
    frame_result_t r;
    r.data   = data;
    r.dest   = dest;
    r.seq    = seq;
    r.is_end = is_end;
    r.status = st;
    r.plen   = plen;
    decoded_q.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] raw);
    logic [7:0]  b;
    int unsigned p;
    b = raw;
    p = rx_pos;
    if (p == 0) begin
      if (b == START_MARK) begin
        crc_acc   = crc16_next(CRC_INIT, b);
        esc_seen  = 1'b0;
        frame_len = '0;
        rx_pos    = 11'd1;
      end
      return;
    end
    if (esc_seen) begin
      b        = b | ESC_BIT;
      esc_seen = 1'b0;
    end else if (b == ESC_MARK) begin
      esc_seen = 1'b1;
      return;
    end
    crc_acc = crc16_next(crc_acc, b);
    rx_pos  = 11'(p + 1);
    if (p == 1) begin
      frame_len = {b, 8'h00};
    end else if (p == 2) begin
      frame_len[7:0] = b;
      // bad lengths end the frame right away, with no header fields
      if (frame_len < 16'd2) begin
        restart_hunt();
        push_result('0, '0, '0, 1'b1, ST_SHORT, '0);
      end else if (frame_len > MAX_PAYLOAD + 2) begin
        restart_hunt();
        push_result('0, '0, '0, 1'b1, ST_LONG, '0);
      end
    end else if (p == 3) begin
      dest_q = b;
    end else if (p == 4) begin
      seq_q = b;
    end else if (p < frame_len + 3) begin
      push_result(b, dest_q, seq_q, 1'b0, ST_OK, '0);
    end else if (p > frame_len + 3) begin
      // last CRC byte: residue must be zero
      push_result('0, dest_q, seq_q, 1'b1, (crc_acc == CRC_ZERO) ? ST_OK : ST_CRC,
                  PLEN_W'(frame_len - 16'd2));
      restart_hunt();
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  task automatic compare_result();
    frame_result_t e;
    if (decoded_q.size() == 0) begin
      $display("%0t: transfer with nothing expected: data %02h end %0b status %0d",
               $time, data_byte_i, frame_end_i, status_i);
      fail_count_o++;
      return;
    end
    e = decoded_q.pop_front();
    check_field("data_byte", e.data, data_byte_i);
    check_field("destination", e.dest, destination_i);
    check_field("sequence_res", e.seq, sequence_res_i);
    check_field("frame_end", e.is_end, frame_end_i);
    check_field("status", e.status, status_i);
    check_field("payload_length", e.plen, payload_length_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_hunt();
      dest_q       = '0;
      seq_q        = '0;
      fail_count_o = 0;
      decoded_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) decode_byte(rx_byte_i);
      if (out_valid_i && out_ready_i) compare_result();
    end
    outstanding_o = decoded_q.size();
  end

endmodule

// ===== tb/escaped_frame_receiver_crc16_top_test.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc16_top_test
// Drives byte-stuffed frames into the receiver: hunting noise, bad lengths,
// good, corrupted and truncated frames with random escaping, and one full
// drain halfway through. Both channels idle at random; the checker scores.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc16_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import efr_pkg::*;
  import efr_tb_pkg::*;

  localparam int unsigned MAX_PAYLOAD  = 1024;
  localparam int unsigned MAX_LEN      = MAX_PAYLOAD + 2;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned STREAM_BYTES = 690;
  localparam int unsigned FULL_FRAME   = 4096;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [7:0]        rx_byte    = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [7:0]        data_byte;
  logic [7:0]        destination;
  logic [7:0]        sequence_res;
  logic              frame_end;
  logic [1:0]        status;
  logic [PLEN_W-1:0] payload_length;
  int unsigned       fail_count;
  int unsigned       outstanding;

  int unsigned       bytes_sent = 0;
  logic              quiet      = 1'b0;
  logic              dup_escape = 1'b0;
  logic [7:0]        payload_q[$];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  escaped_frame_receiver_crc16_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .data_byte_o     (data_byte),
    .destination_o   (destination),
    .sequence_res_o  (sequence_res),
    .frame_end_o     (frame_end),
    .status_o        (status),
    .payload_length_o(payload_length)
  );

  efr_frame_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .data_byte_i     (data_byte),
    .destination_i   (destination),
    .sequence_res_i  (sequence_res),
    .frame_end_i     (frame_end),
    .status_i        (status),
    .payload_length_i(payload_length),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  // Bias toward marks and high bytes so escaping gets exercised
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return ESC_MARK;
      1:       return START_MARK;
      2:       return $urandom_range(0, 1) ? 8'hff : 8'h00;
      3:       return ESC_BIT | 8'($urandom_range(0, 127));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_raw(input logic [7:0] b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
  endtask

  // Escape marks always, high bytes now and then, either low form
  task automatic send_coded(input logic [7:0] b);
    if (b == ESC_MARK) begin
      send_raw(ESC_MARK);
      send_raw((dup_escape || $urandom_range(0, 1)) ? ESC_MARK : (ESC_MARK & ~ESC_BIT));
    end else if (b[7] && $urandom_range(0, 2) == 0) begin
      send_raw(ESC_MARK);
      send_raw($urandom_range(0, 1) ? b : (b & ~ESC_BIT));
    end else begin
      send_raw(b);
    end
  endtask

  // Payload comes from payload_q first, random after; cut stops the frame early
  task automatic send_frame(input int unsigned len, input logic corrupt,
                            input int unsigned cut);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int unsigned idx;
    body.push_back(len[15:8]);
    body.push_back(len[7:0]);
    if (len >= 2 && len <= MAX_LEN) begin
      body.push_back(pick_byte());
      body.push_back(pick_byte());
      while (body.size() < len + 2)
        body.push_back(payload_q.size() != 0 ? payload_q.pop_front() : pick_byte());
      crc = crc16_next(CRC_INIT, START_MARK);
      foreach (body[i]) crc = crc16_next(crc, body[i]);
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
      if (corrupt) begin
        // keep the length intact so only the check fails
        idx       = $urandom_range(2, body.size() - 1);
        body[idx] = body[idx] ^ 8'(1 << $urandom_range(0, 7));
      end
    end
    payload_q.delete();
    send_raw(START_MARK);
    foreach (body[i]) if (i < cut) send_coded(body[i]);
  endtask

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(2, 60) : $urandom_range(2, 10);
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    int unsigned len;
    logic        drain_done;
    logic [7:0]  b;
    drain_done = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hunting drops everything but the start mark
    send_raw(8'h00);
    send_raw(8'hff);
    send_raw(ESC_MARK);
    send_frame(16'h0000, 1'b0, FULL_FRAME);
    send_frame(MAX_LEN + 1, 1'b0, FULL_FRAME);
    send_frame(16'hffff, 1'b0, FULL_FRAME);
    // start mark as data (escaped now and then), then a doubled escape mark
    dup_escape = 1'b1;
    payload_q  = '{START_MARK, ESC_MARK};
    send_frame(4, 1'b0, FULL_FRAME);
    dup_escape = 1'b0;

    while (bytes_sent < STREAM_BYTES) begin
      if ($urandom_range(0, 15) == 0) quiet = ~quiet;
      len = pick_len();
      if (!drain_done && bytes_sent > STREAM_BYTES / 2) begin
        drain_done = 1'b1;
        wait_drained();
      end
      case ($urandom_range(0, 15))
        0: send_frame(len, 1'b1, FULL_FRAME);
        1: send_frame($urandom_range(0, 1) ? $urandom_range(0, 1)
                                            : $urandom_range(MAX_LEN + 1, 16'hffff),
                      1'b0, FULL_FRAME);
        2: begin
          repeat ($urandom_range(1, 4)) begin
            b = pick_byte();
            send_raw(b == START_MARK ? ESC_MARK : b);
          end
        end
        3: send_frame(len, 1'b0, $urandom_range(1, len + 3));
        default: send_frame(len, 1'b0, FULL_FRAME);
      endcase
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Output side: stall a random number of cycles before each transfer
  initial begin
    int unsigned stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/efr_pkg.sv
rtl/core/escaped_frame_receiver_crc16_top.sv
tb/efr_frame_checker.sv
tb/escaped_frame_receiver_crc16_top_test.sv
